>>> hw/rtl/srr_pkg.sv
// ============================================================================
// srr_pkg
// Shared types and constants of the selective-repeat receiver.
// ============================================================================
package srr_pkg;

    // Field widths of requests and results
    localparam int REQ_W      = 2;
    localparam int PROTO_W    = 8;
    localparam int KIND_W     = 8;
    localparam int SEQ_W      = 16;
    localparam int PLEN_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int RCNT_W     = 6;
    localparam int RES_KIND_W = 2;
    localparam int WIN_W      = 13;
    localparam int TAG_W      = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int LIM_W      = 9;

    localparam logic [KIND_W-1:0] DATA_KIND   = 8'd3;
    localparam logic [WIN_W-1:0]  WCAP_RESET  = 13'd4096;
    localparam logic [LIM_W-1:0]  PLIM_RESET  = 9'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROTO = 2'd0,
        CFG_WCAP  = 2'd1,
        CFG_PLIM  = 2'd2,
        CFG_CONN  = 2'd3
    } t_cfg_idx;

    typedef enum logic [REQ_W-1:0] {
        REQ_HEADER = 2'd0,
        REQ_BYTE   = 2'd1,
        REQ_READ   = 2'd2
    } t_req;

    typedef enum logic [RES_KIND_W-1:0] {
        RES_ACK   = 2'd0,
        RES_BYTE  = 2'd1,
        RES_EMPTY = 2'd2
    } t_res_kind;

    typedef enum logic [1:0] {
        ACT_IDLE    = 2'd0,
        ACT_COLLECT = 2'd1,
        ACT_DISCARD = 2'd2
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COMPLETE,
        ST_DRAIN,
        ST_DLEN,
        ST_COPY,
        ST_ACK,
        ST_EMPTY,
        ST_RD,
        ST_RDW
    } t_state;

endpackage

>>> hw/rtl/srr_in_if.sv
// ============================================================================
// srr_in_if
// Request channel: segment header, payload byte or application read.
// ============================================================================
interface srr_in_if;
    logic                           valid;
    logic                           ready;
    logic [srr_pkg::REQ_W-1:0]      req_type;
    logic [srr_pkg::PROTO_W-1:0]    proto_field;
    logic [srr_pkg::KIND_W-1:0]     segment_kind;
    logic [srr_pkg::SEQ_W-1:0]      seq_number;
    logic [srr_pkg::PLEN_W-1:0]     payload_length;
    logic [srr_pkg::BYTE_W-1:0]     payload_byte;
    logic [srr_pkg::RCNT_W-1:0]     read_count;

    modport source (
        output valid, req_type, proto_field, segment_kind, seq_number,
               payload_length, payload_byte, read_count,
        input  ready
    );
    modport sink (
        input  valid, req_type, proto_field, segment_kind, seq_number,
               payload_length, payload_byte, read_count,
        output ready
    );
endinterface

>>> hw/rtl/srr_out_if.sv
// ============================================================================
// srr_out_if
// Result channel: acknowledgements, delivered bytes and empty status.
// ============================================================================
interface srr_out_if;
    logic                             valid;
    logic                             ready;
    logic [srr_pkg::RES_KIND_W-1:0]   result_kind;
    logic [srr_pkg::SEQ_W-1:0]        ack_number;
    logic [srr_pkg::WIN_W-1:0]        free_window;
    logic [srr_pkg::TAG_W-1:0]        conn_tag;
    logic [srr_pkg::BYTE_W-1:0]       delivered_byte;
    logic                             last_of_run;

    modport source (
        output valid, result_kind, ack_number, free_window, conn_tag,
               delivered_byte, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, result_kind, ack_number, free_window, conn_tag,
               delivered_byte, last_of_run,
        output ready
    );
endinterface

>>> hw/rtl/srr_ram.sv
// ============================================================================
// srr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module srr_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/selective_repeat_receiver.sv
// ============================================================================
// selective_repeat_receiver
// Selective-repeat receiver for one connection: slot store, in-order drain
// into a delivery FIFO, acknowledgements and application reads.
// ============================================================================
// Header and payload-byte requests are taken in idle; an old header also loads an ack.
// A completing segment is stored, then each in-order slot is drained on the slot RAM
// port: its length is read and its bytes are copied into the delivery FIFO, then an ack.
// A read returns bytes from the FIFO RAM port, then an ack, or an empty status.
// Results leave through one output register; a held result stalls the next load.
// Reset is synchronous, active low, clears counters and slot valid bits, not the RAMs.
module selective_repeat_receiver #(
    parameter int SLOT_COUNT    = 16,
    parameter int SEGMENT_BYTES = 256,
    parameter int BUFFER_BYTES  = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    srr_in_if.sink                            i_req,
    srr_out_if.source                         o_res,
    input  logic                              i_cfg_wr_en,
    input  logic [srr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [srr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int SLOT_W   = $clog2(SLOT_COUNT);
    localparam int SEG_W    = $clog2(SEGMENT_BYTES);
    localparam int LEN_W    = $clog2(SEGMENT_BYTES + 1);
    localparam int SD_DEPTH = SLOT_COUNT * (2 ** SEG_W);
    localparam int SD_AW    = SLOT_W + SEG_W;
    localparam int FIFO_AW  = $clog2(BUFFER_BYTES);
    localparam int CNT_W    = $clog2(BUFFER_BYTES + 1);
    localparam int WIN_W    = srr_pkg::WIN_W;
    localparam int SEQ_W    = srr_pkg::SEQ_W;
    localparam int RCNT_W   = srr_pkg::RCNT_W;

    // Configuration registers
    logic [srr_pkg::PROTO_W-1:0] r_pid;
    logic [WIN_W-1:0]            r_wcap;
    logic [srr_pkg::LIM_W-1:0]   r_plim;
    logic [srr_pkg::TAG_W-1:0]   r_conn;

    // Receiver state
    srr_pkg::t_state     r_state, n_state;
    srr_pkg::t_action    r_act;
    logic [SEQ_W-1:0]    r_ne;
    logic [SLOT_W-1:0]   r_ne_idx;
    logic [WIN_W-1:0]    r_held;
    logic [SLOT_COUNT-1:0] r_slot_valid;
    logic [LEN_W-1:0]    r_plen;
    logic [LEN_W-1:0]    r_seen;
    logic [SLOT_W-1:0]   r_pidx;
    logic                r_pinwin;
    logic [FIFO_AW-1:0]  r_head;
    logic [FIFO_AW-1:0]  r_tail;
    logic [CNT_W-1:0]    r_fcnt;
    logic [RCNT_W-1:0]   r_rem;
    logic [LEN_W-1:0]    r_clen;
    logic [LEN_W-1:0]    r_i;
    logic                r_wpend;

    // Output register
    logic                         r_ov;
    srr_pkg::t_res_kind           r_o_kind;
    logic [SEQ_W-1:0]             r_o_ack;
    logic [WIN_W-1:0]             r_o_win;
    logic [srr_pkg::TAG_W-1:0]    r_o_tag;
    logic [srr_pkg::BYTE_W-1:0]   r_o_byte;
    logic                         r_o_last;

    // Combinational helpers
    logic                acc;
    logic                out_free;
    logic                ld_ack, ld_byte, ld_empty;
    logic [WIN_W-1:0]    eff_cap;
    logic [LEN_W-1:0]    eff_lim;
    logic [WIN_W-1:0]    free_sp;
    logic                hdr_ok, seq_old, hdr_zero, hdr_inwin;
    logic [SEQ_W-1:0]    hdr_dist;
    logic [SLOT_W:0]     hdr_sum;
    logic [SLOT_W-1:0]   hdr_idx;
    logic                last_byte;
    logic [RCNT_W-1:0]   rd_size;
    logic                store_ok;
    logic                cp_issue, cp_done;
    logic                fifo_wr;
    logic                sd_we;
    logic [LEN_W-1:0]    slen_rdata;
    logic [srr_pkg::BYTE_W-1:0] sd_rdata, fifo_rdata;

    assign acc      = i_req.valid && i_req.ready;
    assign out_free = !r_ov || o_res.ready;

    // Effective capacity, limit and free window
    always_comb begin
        if (17'(r_wcap) > 17'(BUFFER_BYTES)) begin
            eff_cap = WIN_W'(BUFFER_BYTES);
        end else begin
            eff_cap = r_wcap;
        end
        if (16'(r_plim) > 16'(SEGMENT_BYTES)) begin
            eff_lim = LEN_W'(SEGMENT_BYTES);
        end else begin
            eff_lim = LEN_W'(r_plim);
        end
        free_sp = (r_held >= eff_cap) ? '0 : eff_cap - r_held;
    end

    // Header decode: validity, age and slot index relative to next expected
    always_comb begin
        hdr_ok    = (i_req.proto_field == r_pid) &&
                    (i_req.segment_kind == srr_pkg::DATA_KIND) &&
                    (i_req.payload_length <= 16'(eff_lim));
        seq_old   = i_req.seq_number < r_ne;
        hdr_zero  = i_req.payload_length == '0;
        hdr_dist  = i_req.seq_number - r_ne;
        hdr_inwin = hdr_dist < 16'(SLOT_COUNT);
        hdr_sum   = (SLOT_W + 1)'(r_ne_idx) + (SLOT_W + 1)'(hdr_dist[SLOT_W-1:0]);
        if (hdr_sum >= (SLOT_W + 1)'(SLOT_COUNT)) begin
            hdr_idx = SLOT_W'(hdr_sum - (SLOT_W + 1)'(SLOT_COUNT));
        end else begin
            hdr_idx = SLOT_W'(hdr_sum);
        end
    end

    assign last_byte = (LEN_W + 1)'(r_seen) + (LEN_W + 1)'(1) >= (LEN_W + 1)'(r_plen);
    assign rd_size   = (17'(r_fcnt) < 17'(i_req.read_count)) ? RCNT_W'(r_fcnt)
                                                             : i_req.read_count;
    assign store_ok  = r_pinwin && (16'(free_sp) >= 16'(r_plen)) && !r_slot_valid[r_pidx];
    assign cp_issue  = r_i < r_clen;
    assign cp_done   = !cp_issue && !r_wpend;
    assign fifo_wr   = (r_state == srr_pkg::ST_COPY) && r_wpend &&
                       (r_fcnt < CNT_W'(BUFFER_BYTES));
    assign sd_we     = acc && (srr_pkg::t_req'(i_req.req_type) == srr_pkg::REQ_BYTE) &&
                       (r_act == srr_pkg::ACT_COLLECT) && r_pinwin && !r_slot_valid[r_pidx];

    // Slot payload store
    srr_ram #(.DEPTH(SD_DEPTH), .WIDTH(srr_pkg::BYTE_W)) u_slot_data (
        .i_clk   (i_clk),
        .i_we    (sd_we),
        .i_waddr (SD_AW'({r_pidx, r_seen[SEG_W-1:0]})),
        .i_wdata (i_req.payload_byte),
        .i_re    ((r_state == srr_pkg::ST_COPY) && cp_issue),
        .i_raddr (SD_AW'({r_ne_idx, r_i[SEG_W-1:0]})),
        .o_rdata (sd_rdata)
    );

    // Slot length store
    srr_ram #(.DEPTH(SLOT_COUNT), .WIDTH(LEN_W)) u_slot_len (
        .i_clk   (i_clk),
        .i_we    ((r_state == srr_pkg::ST_COMPLETE) && store_ok),
        .i_waddr (r_pidx),
        .i_wdata (r_plen),
        .i_re    ((r_state == srr_pkg::ST_DRAIN) && r_slot_valid[r_ne_idx]),
        .i_raddr (r_ne_idx),
        .o_rdata (slen_rdata)
    );

    // Delivery FIFO store
    srr_ram #(.DEPTH(BUFFER_BYTES), .WIDTH(srr_pkg::BYTE_W)) u_fifo (
        .i_clk   (i_clk),
        .i_we    (fifo_wr),
        .i_waddr (r_tail),
        .i_wdata (sd_rdata),
        .i_re    ((r_state == srr_pkg::ST_RD) && (r_rem != '0)),
        .i_raddr (r_head),
        .o_rdata (fifo_rdata)
    );

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and result loads
    always_comb begin
        n_state  = r_state;
        ld_ack   = 1'b0;
        ld_byte  = 1'b0;
        ld_empty = 1'b0;
        case (r_state)
            srr_pkg::ST_IDLE: begin
                if (acc) begin
                    case (srr_pkg::t_req'(i_req.req_type))
                        srr_pkg::REQ_HEADER: begin
                            if (hdr_ok && seq_old) begin
                                n_state = srr_pkg::ST_ACK;
                            end else if (hdr_ok && hdr_zero) begin
                                n_state = srr_pkg::ST_COMPLETE;
                            end
                        end
                        srr_pkg::REQ_BYTE: begin
                            if (r_act == srr_pkg::ACT_COLLECT && last_byte) begin
                                n_state = srr_pkg::ST_COMPLETE;
                            end
                        end
                        srr_pkg::REQ_READ: begin
                            n_state = (rd_size == '0) ? srr_pkg::ST_EMPTY : srr_pkg::ST_RD;
                        end
                        default: ;
                    endcase
                end
            end
            srr_pkg::ST_COMPLETE: n_state = srr_pkg::ST_DRAIN;
            srr_pkg::ST_DRAIN: begin
                n_state = r_slot_valid[r_ne_idx] ? srr_pkg::ST_DLEN : srr_pkg::ST_ACK;
            end
            srr_pkg::ST_DLEN: n_state = srr_pkg::ST_COPY;
            srr_pkg::ST_COPY: begin
                if (cp_done) begin
                    n_state = srr_pkg::ST_DRAIN;
                end
            end
            srr_pkg::ST_ACK: begin
                if (out_free) begin
                    ld_ack  = 1'b1;
                    n_state = srr_pkg::ST_IDLE;
                end
            end
            srr_pkg::ST_EMPTY: begin
                if (out_free) begin
                    ld_empty = 1'b1;
                    n_state  = srr_pkg::ST_IDLE;
                end
            end
            srr_pkg::ST_RD: begin
                n_state = (r_rem == '0) ? srr_pkg::ST_ACK : srr_pkg::ST_RDW;
            end
            srr_pkg::ST_RDW: begin
                if (out_free) begin
                    ld_byte = 1'b1;
                    n_state = srr_pkg::ST_RD;
                end
            end
            default: n_state = srr_pkg::ST_IDLE;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pid  <= '0;
            r_wcap <= srr_pkg::WCAP_RESET;
            r_plim <= srr_pkg::PLIM_RESET;
            r_conn <= '0;
        end else if (i_cfg_wr_en) begin
            case (srr_pkg::t_cfg_idx'(i_cfg_index))
                srr_pkg::CFG_PROTO: r_pid  <= srr_pkg::PROTO_W'(i_cfg_data);
                srr_pkg::CFG_WCAP:  r_wcap <= WIN_W'(i_cfg_data);
                srr_pkg::CFG_PLIM:  r_plim <= srr_pkg::LIM_W'(i_cfg_data);
                srr_pkg::CFG_CONN:  r_conn <= srr_pkg::TAG_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Receiver datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act        <= srr_pkg::ACT_IDLE;
            r_ne         <= '0;
            r_ne_idx     <= '0;
            r_held       <= '0;
            r_slot_valid <= '0;
            r_plen       <= '0;
            r_seen       <= '0;
            r_pidx       <= '0;
            r_pinwin     <= 1'b0;
            r_head       <= '0;
            r_tail       <= '0;
            r_fcnt       <= '0;
            r_rem        <= '0;
            r_clen       <= '0;
            r_i          <= '0;
            r_wpend      <= 1'b0;
        end else begin
            case (r_state)
                srr_pkg::ST_IDLE: begin
                    if (acc) begin
                        case (srr_pkg::t_req'(i_req.req_type))
                            srr_pkg::REQ_HEADER: begin
                                if (!hdr_ok) begin
                                    r_act <= srr_pkg::ACT_IDLE;
                                end else begin
                                    r_plen   <= LEN_W'(i_req.payload_length);
                                    r_seen   <= '0;
                                    r_pidx   <= hdr_idx;
                                    r_pinwin <= hdr_inwin;
                                    if (!seq_old) begin
                                        r_act <= srr_pkg::ACT_COLLECT;
                                    end else if (hdr_zero) begin
                                        r_act <= srr_pkg::ACT_IDLE;
                                    end else begin
                                        r_act <= srr_pkg::ACT_DISCARD;
                                    end
                                end
                            end
                            srr_pkg::REQ_BYTE: begin
                                if (r_act != srr_pkg::ACT_IDLE) begin
                                    r_seen <= r_seen + LEN_W'(1);
                                    if (last_byte && r_act == srr_pkg::ACT_DISCARD) begin
                                        r_act <= srr_pkg::ACT_IDLE;
                                    end
                                end
                            end
                            srr_pkg::REQ_READ: begin
                                r_rem  <= rd_size;
                                r_fcnt <= r_fcnt - CNT_W'(rd_size);
                                r_held <= (r_held >= WIN_W'(rd_size))
                                          ? r_held - WIN_W'(rd_size) : '0;
                            end
                            default: ;
                        endcase
                    end
                end
                // Store the collected segment if it is in the window, fits and its slot is free
                srr_pkg::ST_COMPLETE: begin
                    r_act <= srr_pkg::ACT_IDLE;
                    if (store_ok) begin
                        r_slot_valid[r_pidx] <= 1'b1;
                        r_held               <= r_held + WIN_W'(r_plen);
                    end
                end
                srr_pkg::ST_DLEN: begin
                    r_clen  <= slen_rdata;
                    r_i     <= '0;
                    r_wpend <= 1'b0;
                end
                // Stream one slot into the delivery FIFO, then advance
                srr_pkg::ST_COPY: begin
                    r_wpend <= cp_issue;
                    if (cp_issue) begin
                        r_i <= r_i + LEN_W'(1);
                    end
                    if (fifo_wr) begin
                        r_tail <= (r_tail == FIFO_AW'(BUFFER_BYTES - 1))
                                  ? '0 : r_tail + FIFO_AW'(1);
                        r_fcnt <= r_fcnt + CNT_W'(1);
                    end
                    if (cp_done) begin
                        r_slot_valid[r_ne_idx] <= 1'b0;
                        r_ne <= r_ne + SEQ_W'(1);
                        if (r_ne == '1 || r_ne_idx == SLOT_W'(SLOT_COUNT - 1)) begin
                            r_ne_idx <= '0;
                        end else begin
                            r_ne_idx <= r_ne_idx + SLOT_W'(1);
                        end
                    end
                end
                srr_pkg::ST_RD: begin
                    if (r_rem != '0) begin
                        r_rem  <= r_rem - RCNT_W'(1);
                        r_head <= (r_head == FIFO_AW'(BUFFER_BYTES - 1))
                                  ? '0 : r_head + FIFO_AW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Result output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (ld_ack || ld_byte || ld_empty) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_ack) begin
            r_o_kind <= srr_pkg::RES_ACK;
            r_o_ack  <= r_ne;
            r_o_win  <= free_sp;
            r_o_tag  <= r_conn;
            r_o_byte <= '0;
            r_o_last <= 1'b1;
        end else if (ld_byte) begin
            r_o_kind <= srr_pkg::RES_BYTE;
            r_o_ack  <= '0;
            r_o_win  <= '0;
            r_o_tag  <= '0;
            r_o_byte <= fifo_rdata;
            r_o_last <= 1'b0;
        end else if (ld_empty) begin
            r_o_kind <= srr_pkg::RES_EMPTY;
            r_o_ack  <= '0;
            r_o_win  <= '0;
            r_o_tag  <= '0;
            r_o_byte <= '0;
            r_o_last <= 1'b1;
        end
    end

    assign i_req.ready          = (r_state == srr_pkg::ST_IDLE);
    assign o_res.valid          = r_ov;
    assign o_res.result_kind    = r_o_kind;
    assign o_res.ack_number     = r_o_ack;
    assign o_res.free_window    = r_o_win;
    assign o_res.conn_tag       = r_o_tag;
    assign o_res.delivered_byte = r_o_byte;
    assign o_res.last_of_run    = r_o_last;

    // FIFO occupancy never exceeds the buffer
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= CNT_W'(BUFFER_BYTES))
        else $error("delivery FIFO count above buffer size");

    // Drain only copies from a stored slot
    a_copy_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == srr_pkg::ST_COPY |-> r_slot_valid[r_ne_idx])
        else $error("drain copying from an empty slot");

    // Every ack and empty status closes its run
    a_ack_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && (r_o_kind == srr_pkg::RES_ACK || r_o_kind == srr_pkg::RES_EMPTY)
        |-> r_o_last)
        else $error("ack without end-of-run mark");

    // A loaded byte is presented as a byte result that does not close its run
    a_byte_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_byte |=> r_ov && r_o_kind == srr_pkg::RES_BYTE && !r_o_last)
        else $error("delivered byte not presented");

endmodule

>>> dv/tb_selective_repeat_receiver.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_selective_repeat_receiver
// Self-checking bench for the selective-repeat receiver: drives headers,
// payload bytes and reads under random idling and a long output hold-off,
// keeps its own model of slots, window and delivery FIFO, and compares every
// result field by field, in order, against the predicted stream.
// ============================================================================
module tb_selective_repeat_receiver;

    localparam int SLOTS      = 16;
    localparam int SEG_BYTES  = 256;
    localparam int BUF_BYTES  = 4096;
    localparam int QUIET_WAIT = 40;
    localparam int STALL_MAX  = 20000;
    localparam int HOLD_LEN   = 400;

    localparam int REQ_W      = srr_pkg::REQ_W;
    localparam int PROTO_W    = srr_pkg::PROTO_W;
    localparam int KIND_W     = srr_pkg::KIND_W;
    localparam int SEQ_W      = srr_pkg::SEQ_W;
    localparam int PLEN_W     = srr_pkg::PLEN_W;
    localparam int BYTE_W     = srr_pkg::BYTE_W;
    localparam int RCNT_W     = srr_pkg::RCNT_W;
    localparam int WIN_W      = srr_pkg::WIN_W;
    localparam int TAG_W      = srr_pkg::TAG_W;
    localparam int LIM_W      = srr_pkg::LIM_W;
    localparam int CFG_IDX_W  = srr_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = srr_pkg::CFG_DATA_W;

    typedef struct {
        logic [REQ_W-1:0]   req;
        logic [PROTO_W-1:0] proto;
        logic [KIND_W-1:0]  kind;
        logic [SEQ_W-1:0]   seq;
        logic [PLEN_W-1:0]  len;
        logic [BYTE_W-1:0]  data;
        logic [RCNT_W-1:0]  count;
    } t_request;

    typedef struct {
        srr_pkg::t_res_kind kind;
        logic [SEQ_W-1:0]   ack;
        logic [WIN_W-1:0]   win;
        logic [TAG_W-1:0]   tag;
        logic [BYTE_W-1:0]  data;
        logic               last;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    srr_in_if  req_if ();
    srr_out_if res_if ();

    selective_repeat_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_res       (res_if),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Receiver model state
    logic [PROTO_W-1:0] m_proto;
    logic [WIN_W-1:0]   m_wcap;
    logic [LIM_W-1:0]   m_plim;
    logic [TAG_W-1:0]   m_conn;
    logic [SEQ_W-1:0]   m_next;
    int                 m_held;
    logic               m_slot_valid [SLOTS];
    int                 m_slot_len   [SLOTS];
    logic [7:0]         m_slot_data  [SLOTS*SEG_BYTES];
    logic [7:0]         m_fifo [$];
    logic [SEQ_W-1:0]   m_pseq;
    logic [PLEN_W-1:0]  m_plen;
    logic [PLEN_W-1:0]  m_seen;
    srr_pkg::t_action   m_action;

    t_result expected_results [$];
    int      err_cnt;
    int      stall_cnt;
    bit      idle_en;
    bit      hold_trigger;
    int      hold_left;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Model of the receiver
    // ------------------------------------------------------------------------
    function automatic int free_window();
        int cap;
        cap = (m_wcap > BUF_BYTES) ? BUF_BYTES : int'(m_wcap);
        return (m_held >= cap) ? 0 : cap - m_held;
    endfunction

    function automatic void add_result(srr_pkg::t_res_kind k, logic [SEQ_W-1:0] a, int w,
                                       logic [TAG_W-1:0] t, logic [7:0] d, logic l);
        t_result r;
        r.kind = k; r.ack = a; r.win = w[WIN_W-1:0]; r.tag = t; r.data = d; r.last = l;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void add_ack();
        add_result(srr_pkg::RES_ACK, m_next, free_window(), m_conn, 8'd0, 1'b1);
    endfunction

    function automatic void finish_segment();
        int idx;
        idx = m_pseq % SLOTS;
        // store when in window, space allows and slot is free
        if (m_pseq >= m_next && int'(m_pseq - m_next) < SLOTS &&
            free_window() >= int'(m_plen) && !m_slot_valid[idx]) begin
            m_slot_valid[idx] = 1'b1;
            m_slot_len[idx]   = m_plen;
            m_held += m_plen;
        end
        // drain in-order slots into the delivery FIFO
        idx = m_next % SLOTS;
        while (m_slot_valid[idx]) begin
            for (int i = 0; i < m_slot_len[idx] && i < SEG_BYTES; i++)
                if (m_fifo.size() < BUF_BYTES)
                    m_fifo.insert(m_fifo.size(), m_slot_data[idx*SEG_BYTES+i]);
            m_slot_valid[idx] = 1'b0;
            m_next = m_next + 1'b1;
            idx = m_next % SLOTS;
        end
        m_action = srr_pkg::ACT_IDLE;
    endfunction

    function automatic void predict_request(t_request q);
        int lim, idx, size;
        lim = (m_plim > SEG_BYTES) ? SEG_BYTES : int'(m_plim);
        case (q.req)
            srr_pkg::REQ_HEADER: begin
                if (q.proto != m_proto || q.kind != srr_pkg::DATA_KIND ||
                    int'(q.len) > lim) begin
                    m_action = srr_pkg::ACT_IDLE;
                end else begin
                    m_pseq = q.seq; m_plen = q.len; m_seen = '0;
                    if (q.seq < m_next) begin
                        m_action = (q.len == 0) ? srr_pkg::ACT_IDLE : srr_pkg::ACT_DISCARD;
                        add_ack();
                    end else begin
                        m_action = srr_pkg::ACT_COLLECT;
                        if (q.len == 0) begin
                            finish_segment();
                            add_ack();
                        end
                    end
                end
            end
            srr_pkg::REQ_BYTE: begin
                idx = m_pseq % SLOTS;
                if (m_action != srr_pkg::ACT_IDLE) begin
                    if (m_action == srr_pkg::ACT_COLLECT && !m_slot_valid[idx] &&
                        m_seen < SEG_BYTES)
                        m_slot_data[idx*SEG_BYTES + m_seen] = q.data;
                    m_seen = m_seen + 1'b1;
                    if (m_seen >= m_plen) begin
                        if (m_action == srr_pkg::ACT_COLLECT) begin
                            finish_segment();
                            add_ack();
                        end
                        m_action = srr_pkg::ACT_IDLE;
                    end
                end
            end
            srr_pkg::REQ_READ: begin
                size = (q.count < m_fifo.size()) ? int'(q.count) : m_fifo.size();
                if (size == 0) begin
                    add_result(srr_pkg::RES_EMPTY, '0, 0, '0, 8'd0, 1'b1);
                end else begin
                    for (int i = 0; i < size; i++)
                        add_result(srr_pkg::RES_BYTE, '0, 0, '0, m_fifo.pop_front(), 1'b0);
                    m_held = (m_held >= size) ? m_held - size : 0;
                    add_ack();
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (err_cnt < 30) $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                e = expected_results.pop_front();
                if (res_if.result_kind != e.kind)
                    report_mismatch($sformatf("kind %0d exp %0d", res_if.result_kind, e.kind));
                if (res_if.ack_number != e.ack)
                    report_mismatch($sformatf("ack %0d exp %0d", res_if.ack_number, e.ack));
                if (res_if.free_window != e.win)
                    report_mismatch($sformatf("window %0d exp %0d", res_if.free_window, e.win));
                if (res_if.conn_tag != e.tag)
                    report_mismatch($sformatf("tag %0d exp %0d", res_if.conn_tag, e.tag));
                if (res_if.delivered_byte != e.data)
                    report_mismatch($sformatf("byte %0h exp %0h", res_if.delivered_byte, e.data));
                if (res_if.last_of_run != e.last)
                    report_mismatch($sformatf("last %0b exp %0b", res_if.last_of_run, e.last));
            end
        end
    end

    // Result ready: random stalls plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_trigger) begin
            hold_trigger = 1'b0;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= !(idle_en && $urandom_range(99) < 9);
        end
    end

    // Watchdog: count cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            stall_cnt = 0;
        else
            stall_cnt++;
        if (stall_cnt >= STALL_MAX) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_request(input t_request q);
        if (idle_en && $urandom_range(99) < 9) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.req_type       <= q.req;
        req_if.proto_field    <= q.proto;
        req_if.segment_kind   <= q.kind;
        req_if.seq_number     <= q.seq;
        req_if.payload_length <= q.len;
        req_if.payload_byte   <= q.data;
        req_if.read_count     <= q.count;
        do @(posedge i_clk); while (!req_if.ready);
        predict_request(q);
    endtask

    function automatic t_request mk_header(logic [PROTO_W-1:0] p, logic [KIND_W-1:0] k,
                                           logic [SEQ_W-1:0] s, logic [PLEN_W-1:0] l);
        t_request q;
        q.req = srr_pkg::REQ_HEADER; q.proto = p; q.kind = k; q.seq = s; q.len = l;
        q.data = $urandom; q.count = $urandom;
        return q;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        t_request q;
        q = mk_header($urandom, $urandom, $urandom, $urandom);
        q.req = srr_pkg::REQ_BYTE; q.data = b;
        send_request(q);
    endtask

    task automatic send_read(input logic [RCNT_W-1:0] n);
        t_request q;
        q = mk_header($urandom, $urandom, $urandom, $urandom);
        q.req = srr_pkg::REQ_READ; q.count = n;
        send_request(q);
    endtask

    // Header plus sent_bytes payload bytes of random content
    task automatic send_segment(input logic [SEQ_W-1:0] s, input int len, input int sent_bytes);
        send_request(mk_header(m_proto, srr_pkg::DATA_KIND, s, len[PLEN_W-1:0]));
        for (int i = 0; i < sent_bytes; i++) send_byte($urandom);
    endtask

    // Drop valid and wait for the block to go quiet
    task automatic wait_quiet();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0 || hold_left > 0) @(posedge i_clk);
        repeat (QUIET_WAIT) @(posedge i_clk);
    endtask

    task automatic write_cfg(input srr_pkg::t_cfg_idx idx, input logic [CFG_DATA_W-1:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        case (idx)
            srr_pkg::CFG_PROTO: m_proto = v[PROTO_W-1:0];
            srr_pkg::CFG_WCAP:  m_wcap  = v;
            srr_pkg::CFG_PLIM:  m_plim  = v[LIM_W-1:0];
            srr_pkg::CFG_CONN:  m_conn  = v[TAG_W-1:0];
            default: ;
        endcase
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] p, input int w, input int l, input logic [7:0] c);
        write_cfg(srr_pkg::CFG_PROTO, CFG_DATA_W'(p));
        write_cfg(srr_pkg::CFG_WCAP, w[CFG_DATA_W-1:0]);
        write_cfg(srr_pkg::CFG_PLIM, l[CFG_DATA_W-1:0]);
        write_cfg(srr_pkg::CFG_CONN, CFG_DATA_W'(c));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        t_request q;
        set_config(8'h5A, 4096, 256, 8'hC3);
        send_request(mk_header(8'hA5, srr_pkg::DATA_KIND, 16'd0, 16'd4)); // wrong protocol
        send_byte(8'hFF);                                           // stray byte
        send_request(mk_header(m_proto, 8'hFF, 16'd0, 16'd4));     // not a data kind
        send_request(mk_header(m_proto, srr_pkg::DATA_KIND, 16'hFFFF, 16'hFFFF)); // too long
        send_segment(16'd1, 3, 3);                                  // out of order
        send_segment(16'd0, 40, 42);                                // fills gap, extra bytes
        send_segment(16'd2, 0, 0);                                  // zero length in order
        send_segment(16'd0, 5, 5);                                  // old: swallowed
        send_segment(16'd5, 4, 2);                                  // abandoned
        send_segment(16'd5, 2, 2);
        send_segment(16'd5, 2, 2);                                  // slot busy
        send_segment(16'd3 + SLOTS, 1, 1);                          // beyond slot window
        send_segment(16'hFFFF, 0, 0);                               // far beyond window
        q = mk_header(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        q.req = 2'd3;                                               // unused request
        send_request(q);
        send_read(6'd0);
        send_read(6'd63);
        for (int i = 0; i < 5; i++) send_read(6'd63);
        send_read(6'd1);
        wait_quiet();
    endtask

    task automatic test_small_window();
        // one-byte window and limit, extreme tags
        set_config(8'hFF, 1, 1, 8'hFF);
        send_segment(m_next, 2, 2);
        send_segment(m_next + 1'b1, 1, 1);
        send_segment(m_next, 1, 1);
        send_segment(m_next, 1, 1);
        send_read(6'd1);
        send_segment(m_next, 1, 1);
        wait_quiet();
        // capacity lowered below the bytes held
        set_config(8'h00, 8191, 511, 8'h00);
        send_segment(m_next, 100, 100);
        wait_quiet();
        write_cfg(srr_pkg::CFG_WCAP, 13'd60);
        send_segment(m_next, 10, 10);
        for (int i = 0; i < 2; i++) send_read(6'd63);
        send_segment(m_next, 10, 10);
        send_read(6'd63);
        wait_quiet();
    endtask

    task automatic test_random(input int n_items);
        int sent, r, len, cut, lim;
        logic [SEQ_W-1:0] s;
        t_request q;
        sent = 0;
        set_config($urandom, $urandom_range(300, 4096), $urandom_range(24, 256), $urandom);
        while (sent < n_items) begin
            r = $urandom_range(99);
            lim = (m_plim > SEG_BYTES) ? SEG_BYTES : int'(m_plim);
            len = ($urandom_range(99) < 85) ? $urandom_range(0, 24) : $urandom_range(0, lim);
            if (len > lim) len = lim;
            if (r < 55) begin
                s = m_next + $urandom_range(0, 17);
                send_segment(s, len, len);
                sent += len + 1;
            end else if (r < 72) begin
                send_read($urandom);
                sent++;
            end else if (r < 80) begin
                cut = $urandom_range(0, len);
                send_segment(m_next + $urandom_range(0, 3), len, cut);
                sent += cut + 1;
            end else if (r < 90) begin
                q = mk_header($urandom, $urandom, $urandom, $urandom);
                q.req = $urandom;
                send_request(q);
            end else begin
                s = (m_next > 0) ? m_next - $urandom_range(1, m_next < 8 ? m_next : 8) : 16'd0;
                send_segment(s, len, len + $urandom_range(0, 1));
                sent += len + 1;
            end
        end
        wait_quiet();
    endtask

    task automatic test_backpressure();
        hold_trigger = 1'b1;
        for (int i = 0; i < 8; i++) begin
            send_segment(m_next + $urandom_range(0, 2), $urandom_range(0, 12), 12);
            send_read($urandom_range(1, 20));
        end
        wait_quiet();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = srr_pkg::CFG_PROTO;
        i_cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.req_type = srr_pkg::REQ_HEADER;
        req_if.proto_field = '0;
        req_if.segment_kind = '0;
        req_if.seq_number = '0;
        req_if.payload_length = '0;
        req_if.payload_byte = '0;
        req_if.read_count = '0;
        res_if.ready = 1'b0;
        err_cnt = 0; stall_cnt = 0; idle_en = 1'b0;
        hold_trigger = 1'b0; hold_left = 0;
        m_proto = '0; m_wcap = srr_pkg::WCAP_RESET; m_plim = srr_pkg::PLIM_RESET; m_conn = '0;
        m_next = '0; m_held = 0; m_pseq = '0; m_plen = '0; m_seen = '0;
        m_action = srr_pkg::ACT_IDLE;
        foreach (m_slot_valid[i]) m_slot_valid[i] = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        idle_en = 1'b1;
        test_small_window();
        test_random(80);
        test_backpressure();
        test_random(60);

        wait_quiet();
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
